### hdl/tpu_pkg.sv
// ----------------------------------------------------------------------------
// tpu_pkg
// Shared types, codes and helpers for the packed tracker pattern unpacker.
// ----------------------------------------------------------------------------
package tpu_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 16;
   localparam int ROW_OUT_W = 6;
   localparam int CHAN_W    = 5;
   localparam int CODE_W    = 5;
   localparam int END_W     = 2;
   localparam int FLAG_W    = 3;
   localparam int PART_W    = 4;

   localparam int ROWS_PER_PATTERN_DEF = 64;
   localparam int CHANNEL_COUNT_DEF    = 32;

   localparam logic [BYTE_W-1:0] EFFECT_FIRST = 8'd1;
   localparam logic [BYTE_W-1:0] EFFECT_LAST  = 8'd25;

   // mask byte flag bits (after shifting down by the channel field)
   localparam int FLAG_NOTE = 0;
   localparam int FLAG_VOL  = 1;
   localparam int FLAG_CMD  = 2;

   // entry parts read so far
   localparam int PART_NOTE  = 0;
   localparam int PART_INSTR = 1;
   localparam int PART_VOL   = 2;
   localparam int PART_INFO  = 3;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_LEN_HI,
      PH_MASK,
      PH_NOTE,
      PH_INSTR,
      PH_VOL,
      PH_CMD,
      PH_INFO
   } phase_type;

   typedef enum logic [END_W-1:0] {
      END_NONE,
      END_ROW,
      END_PATTERN
   } ending_type;

   typedef struct packed {
      logic [ROW_OUT_W-1:0]     row_index;
      logic [CHAN_W-1:0]        channel_index;
      logic                     carries_entry;
      logic                     has_note;
      logic signed [BYTE_W-1:0] note_value;
      logic [BYTE_W-1:0]        instrument_number;
      logic                     has_volume;
      logic [BYTE_W-1:0]        volume_value;
      logic                     has_effect;
      logic [CODE_W-1:0]        effect_code;
      logic [BYTE_W-1:0]        effect_info;
      logic [END_W-1:0]         ending;
   } rsp_type;

   // Pick the next phase from the pending flags at position first or above.
   function automatic phase_type next_phase(input logic [FLAG_W-1:0] flags,
                                            input logic [1:0] first);
      phase_type ph;
      ph = PH_MASK;
      if (first <= 2'd2 && flags[FLAG_CMD]) ph = PH_CMD;
      if (first <= 2'd1 && flags[FLAG_VOL]) ph = PH_VOL;
      if (first == 2'd0 && flags[FLAG_NOTE]) ph = PH_NOTE;
      return ph;
   endfunction

endpackage

### hdl/tpu_parser.sv
// ----------------------------------------------------------------------------
// tpu_parser
// Byte-level parse state machine; builds the result for the byte in hand.
// ----------------------------------------------------------------------------
module tpu_parser #(
   parameter int ROWS_PER_PATTERN = tpu_pkg::ROWS_PER_PATTERN_DEF,
   parameter int CHANNEL_COUNT    = tpu_pkg::CHANNEL_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [tpu_pkg::BYTE_W-1:0]  byte_value,
   input  logic                        starts_pattern,
   input  logic [tpu_pkg::BYTE_W-1:0]  sample_count,
   output logic                        emit,
   output tpu_pkg::rsp_type            result
);
   import tpu_pkg::*;

   localparam int ROW_W = (ROWS_PER_PATTERN > 1) ? $clog2(ROWS_PER_PATTERN) : 1;
   localparam int EXT_W = ROW_W + ROW_OUT_W;

   phase_type           phase_ff, phase_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic                no_limit_ff, no_limit_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   logic [FLAG_W-1:0]   flags_ff, flags_in;
   logic [PART_W-1:0]   parts_ff, parts_in;
   logic [BYTE_W-1:0]   note_ff, note_in;
   logic [BYTE_W-1:0]   instr_ff, instr_in;
   logic [BYTE_W-1:0]   vol_ff, vol_in;
   logic [BYTE_W-1:0]   cmd_ff, cmd_in;
   logic [BYTE_W-1:0]   len_lo_ff, len_lo_in;

   logic                data_byte;
   logic [LEN_W-1:0]    rem_dec;
   logic                exhausted;
   logic                row_last;
   logic                chan_ok;
   logic [LEN_W-1:0]    len_word;
   logic [EXT_W-1:0]    row_ext;

   assign data_byte = step && !starts_pattern && phase_ff != PH_WAIT && phase_ff != PH_LEN_HI;
   assign rem_dec   = rem_ff - LEN_W'(1);
   assign exhausted = data_byte && !no_limit_ff && rem_dec == '0;
   assign row_last  = row_ff == ROW_W'(ROWS_PER_PATTERN - 1);
   assign chan_ok   = {1'b0, chan_in} < (CHAN_W + 1)'(CHANNEL_COUNT);
   assign len_word  = {byte_value, len_lo_ff};
   assign row_ext   = EXT_W'(row_ff);

   // next state
   always_comb begin
      phase_in    = phase_ff;
      rem_in      = rem_ff;
      no_limit_in = no_limit_ff;
      row_in      = row_ff;
      chan_in     = chan_ff;
      flags_in    = flags_ff;
      parts_in    = parts_ff;
      note_in     = note_ff;
      instr_in    = instr_ff;
      vol_in      = vol_ff;
      cmd_in      = cmd_ff;
      len_lo_in   = len_lo_ff;
      if (data_byte && !no_limit_ff) begin
         rem_in = rem_dec;
      end
      if (step && starts_pattern) begin
         len_lo_in = byte_value;
         phase_in  = PH_LEN_HI;
      end else if (step) begin
         unique case (phase_ff)
            PH_WAIT: begin
            end
            PH_LEN_HI: begin
               rem_in      = len_word;
               no_limit_in = len_word == '0;
               row_in      = '0;
               phase_in    = PH_MASK;
            end
            PH_MASK: begin
               if (byte_value == '0) begin
                  if (exhausted || row_last) phase_in = PH_WAIT;
                  else row_in = row_ff + ROW_W'(1);
               end else begin
                  chan_in  = byte_value[CHAN_W-1:0];
                  flags_in = byte_value[BYTE_W-1:CHAN_W];
                  parts_in = '0;
                  phase_in = exhausted ? PH_WAIT : next_phase(byte_value[BYTE_W-1:CHAN_W], 2'd0);
               end
            end
            PH_NOTE: begin
               note_in             = byte_value;
               parts_in[PART_NOTE] = 1'b1;
               phase_in            = exhausted ? PH_WAIT : PH_INSTR;
            end
            PH_INSTR: begin
               instr_in             = byte_value;
               parts_in[PART_INSTR] = 1'b1;
               phase_in             = exhausted ? PH_WAIT : next_phase(flags_ff, 2'd1);
            end
            PH_VOL: begin
               vol_in             = byte_value;
               parts_in[PART_VOL] = 1'b1;
               phase_in           = exhausted ? PH_WAIT : next_phase(flags_ff, 2'd2);
            end
            PH_CMD: begin
               cmd_in   = byte_value;
               phase_in = exhausted ? PH_WAIT : PH_INFO;
            end
            PH_INFO: begin
               parts_in[PART_INFO] = 1'b1;
               phase_in            = exhausted ? PH_WAIT : PH_MASK;
            end
            default: begin
               phase_in = PH_WAIT;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      logic       entry;
      ending_type ending;
      entry  = 1'b0;
      ending = END_NONE;
      emit   = 1'b0;
      result = '0;
      if (data_byte) begin
         if (phase_ff == PH_MASK) begin
            if (byte_value == '0) begin
               emit   = 1'b1;
               ending = (exhausted || row_last) ? END_PATTERN : END_ROW;
            end else if (exhausted) begin
               emit   = 1'b1;
               ending = END_PATTERN;
            end else if (phase_in == PH_MASK && chan_ok) begin
               emit  = 1'b1;
               entry = 1'b1;
            end
         end else if (exhausted) begin
            // length ran out mid-entry: send what was read so far
            emit   = 1'b1;
            ending = END_PATTERN;
            entry  = chan_ok;
         end else if (phase_in == PH_MASK && chan_ok) begin
            emit  = 1'b1;
            entry = 1'b1;
         end
      end
      result.row_index = row_ext[ROW_OUT_W-1:0];
      result.ending    = ending;
      if (entry) begin
         result.channel_index = chan_in;
         result.carries_entry = 1'b1;
         if (parts_in[PART_NOTE]) begin
            result.has_note   = 1'b1;
            result.note_value = note_in;
         end
         if (parts_in[PART_INSTR] && instr_in != '0 && instr_in <= sample_count) begin
            result.instrument_number = instr_in;
         end
         if (parts_in[PART_VOL]) begin
            result.has_volume   = 1'b1;
            result.volume_value = vol_in;
         end
         if (parts_in[PART_INFO] && cmd_in >= EFFECT_FIRST && cmd_in <= EFFECT_LAST) begin
            result.has_effect  = 1'b1;
            result.effect_code = cmd_in[CODE_W-1:0];
            result.effect_info = byte_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         rem_ff      <= '0;
         no_limit_ff <= 1'b0;
         row_ff      <= '0;
         chan_ff     <= '0;
         flags_ff    <= '0;
         parts_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         rem_ff      <= rem_in;
         no_limit_ff <= no_limit_in;
         row_ff      <= row_in;
         chan_ff     <= chan_in;
         flags_ff    <= flags_in;
         parts_ff    <= parts_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff   <= note_in;
      instr_ff  <= instr_in;
      vol_ff    <= vol_in;
      cmd_ff    <= cmd_in;
      len_lo_ff <= len_lo_in;
   end

endmodule

### hdl/tpu_out_reg.sv
// ----------------------------------------------------------------------------
// tpu_out_reg
// Result register on the response channel; frees as soon as the item leaves.
// ----------------------------------------------------------------------------
module tpu_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  tpu_pkg::rsp_type load_data,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output tpu_pkg::rsp_type rsp_data,
   output logic             can_take
);
   import tpu_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### hdl/tracker_pattern_unpacker_top.sv
// Path: an accepted byte sits in the input register; when the result register
// can take its result, the result loads the result register and shows on
// rsp_valid, where it stays until rsp_ready takes it.
// Throughput: one byte per cycle; a stalled result holds the input register.
// Reset: synchronous, active high; parser waits for a pattern start mark,
// sample_count clears to 0, both registers empty.
// ----------------------------------------------------------------------------
// tracker_pattern_unpacker_top
// Unpacks a packed tracker pattern byte stream into channel entries and row ends.
// ----------------------------------------------------------------------------
module tracker_pattern_unpacker_top #(
   parameter int ROWS_PER_PATTERN = tpu_pkg::ROWS_PER_PATTERN_DEF,
   parameter int CHANNEL_COUNT    = tpu_pkg::CHANNEL_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tpu_pkg::BYTE_W-1:0]           csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tpu_pkg::BYTE_W-1:0]           req_byte_value,
   input  logic                                 req_starts_pattern,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tpu_pkg::ROW_OUT_W-1:0]        rsp_row_index,
   output logic [tpu_pkg::CHAN_W-1:0]           rsp_channel_index,
   output logic                                 rsp_carries_entry,
   output logic                                 rsp_has_note,
   output logic signed [tpu_pkg::BYTE_W-1:0]    rsp_note_value,
   output logic [tpu_pkg::BYTE_W-1:0]           rsp_instrument_number,
   output logic                                 rsp_has_volume,
   output logic [tpu_pkg::BYTE_W-1:0]           rsp_volume_value,
   output logic                                 rsp_has_effect,
   output logic [tpu_pkg::CODE_W-1:0]           rsp_effect_code,
   output logic [tpu_pkg::BYTE_W-1:0]           rsp_effect_info,
   output logic [tpu_pkg::END_W-1:0]            rsp_ending
);
   import tpu_pkg::*;

   logic [BYTE_W-1:0] samples_ff;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;
   logic              advance;
   logic              can_take;
   logic              emit;
   rsp_type           result;
   rsp_type           rsp_data;

   // advance the held byte whenever the result register can take its result
   assign advance   = in_valid_ff && can_take;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff  <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) samples_ff <= csr_write_data;
         in_valid_ff <= (req_valid && req_ready) || (in_valid_ff && !advance);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_byte_value;
         in_start_ff <= req_starts_pattern;
      end
   end

   tpu_parser #(
      .ROWS_PER_PATTERN (ROWS_PER_PATTERN),
      .CHANNEL_COUNT    (CHANNEL_COUNT)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .byte_value     (in_byte_ff),
      .starts_pattern (in_start_ff),
      .sample_count   (samples_ff),
      .emit           (emit),
      .result         (result)
   );

   tpu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .can_take  (can_take)
   );

   assign rsp_row_index         = rsp_data.row_index;
   assign rsp_channel_index     = rsp_data.channel_index;
   assign rsp_carries_entry     = rsp_data.carries_entry;
   assign rsp_has_note          = rsp_data.has_note;
   assign rsp_note_value        = rsp_data.note_value;
   assign rsp_instrument_number = rsp_data.instrument_number;
   assign rsp_has_volume        = rsp_data.has_volume;
   assign rsp_volume_value      = rsp_data.volume_value;
   assign rsp_has_effect        = rsp_data.has_effect;
   assign rsp_effect_code       = rsp_data.effect_code;
   assign rsp_effect_info       = rsp_data.effect_info;
   assign rsp_ending            = rsp_data.ending;

   // a result without an entry always closes a row or the pattern
   a_bare_has_ending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_carries_entry |->
         rsp_ending != END_NONE && rsp_channel_index == '0 && !rsp_has_note
         && !rsp_has_volume && !rsp_has_effect && rsp_instrument_number == '0)
      else $error("result without entry is malformed");

   a_effect_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_effect |->
         rsp_effect_code != '0 && rsp_effect_code <= EFFECT_LAST[CODE_W-1:0])
      else $error("effect code outside the effect range");

   a_ending_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ending == END_NONE || rsp_ending == END_ROW
                    || rsp_ending == END_PATTERN)
      else $error("undefined ending code");

   a_instr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_instrument_number <= samples_ff)
      else $error("instrument beyond sample count");

endmodule
